/* hw/rtl/scfr_pkg.sv */
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types and constants of the second-chance frame replacer.
// ----------------------------------------------------------------------------
package scfr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 8;

    localparam int PAGE_ID_W  = 8;
    localparam int S_TDATA_W  = 8;
    localparam int STATUS_W   = 3;
    localparam int FRAME_W    = 3;
    localparam int EVICT_W    = 8;
    localparam int M_TDATA_W  = 16;
    localparam int M_PAD_W    = M_TDATA_W - FRAME_W - EVICT_W;
    localparam int CFG_W      = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic FUNC_ACCESS  = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT     = 3'd0,
        ST_LOAD    = 3'd1,
        ST_REPLACE = 3'd2,
        ST_RELEASE = 3'd3,
        ST_ABSENT  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WALK,
        S_SHIFT_PRE,
        S_SHIFT,
        S_COMMIT,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/second_chance_frame_replacer.sv */
// A hit, a load or an absent release passes the frame scan and the decision before the result
// goes to the output register. A replacement or a release adds the FIFO walk and the entry
// shift, one entry a cycle, plus a setup and a commit state. One word at a time; the next
// word is taken the cycle after the result is loaded into the output register. Reset clears
// state, occupied and reference bits and the FIFO count at once; no clearing pass.
// ----------------------------------------------------------------------------
// second_chance_frame_replacer
// Page frame manager with second-chance victim selection, sequenced over
// a page memory and a FIFO memory.
// ----------------------------------------------------------------------------
module second_chance_frame_replacer #(
    parameter int MAX_FRAMES = scfr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = scfr_pkg::PAGE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scfr_pkg::CFG_W-1:0]        cfg_data,   // frames_in_use
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scfr_pkg::S_TDATA_W-1:0]    s_tdata,    // page_id
    input  logic                              s_tuser,    // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [scfr_pkg::M_TDATA_W-1:0]    m_tdata,    // frame, evicted_page, zero pad
    output logic [scfr_pkg::STATUS_W-1:0]     m_tuser     // status
);

    import scfr_pkg::*;

    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int PW = PAGE_BITS;

    state_t                 state_reg, state_next;
    logic [FW-1:0]          idx_reg, idx_next;
    logic                   hit_reg, hit_next;
    logic                   free_reg, free_next;
    logic                   ul_reg, ul_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [MAX_FRAMES-1:0]  valid_reg, valid_next;
    logic [MAX_FRAMES-1:0]  ref_reg, ref_next;
    logic [CFG_W-1:0]       cfg_reg;
    logic                   m_valid_reg, m_valid_next;

    logic                   func_reg;
    logic [PW-1:0]          page_reg;
    logic [CW-1:0]          act_reg, act_next;
    logic [FW-1:0]          hit_idx_reg, hit_idx_next;
    logic [FW-1:0]          free_idx_reg, free_idx_next;
    logic [FW-1:0]          frame_reg, frame_next;
    logic [FW-1:0]          head_reg, head_next;
    status_t                res_status_reg, res_status_next;
    logic [FW-1:0]          res_frame_reg, res_frame_next;
    logic [PW-1:0]          res_evict_reg, res_evict_next;
    status_t                m_status_reg;
    logic [FRAME_W-1:0]     m_frame_reg;
    logic [EVICT_W-1:0]     m_evict_reg;

    logic                   accept;
    logic                   load_m;
    logic                   pg_we;
    logic [FW-1:0]          pg_waddr, pg_raddr;
    logic [PW-1:0]          pg_wdata, pg_rdata;
    logic                   ff_we;
    logic [FW-1:0]          ff_waddr, ff_raddr;
    logic [FW-1:0]          ff_wdata, ff_rdata;

    scfr_ram #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (PW),
        .AW    (FW)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    scfr_ram #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (FW),
        .AW    (FW)
    ) u_fifo_ram (
        .aclk  (aclk),
        .we    (ff_we),
        .waddr (ff_waddr),
        .wdata (ff_wdata),
        .raddr (ff_raddr),
        .rdata (ff_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {{M_PAD_W{1'b0}}, m_evict_reg, m_frame_reg};

    // clamp of frames_in_use
    always_comb begin
        if (cfg_reg == '0) begin
            act_next = CW'(1);
        end else if (int'(cfg_reg) > MAX_FRAMES) begin
            act_next = CW'(MAX_FRAMES);
        end else begin
            act_next = CW'(cfg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            ul_reg      <= 1'b0;
            count_reg   <= '0;
            valid_reg   <= '0;
            ref_reg     <= '0;
            cfg_reg     <= CFG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            ul_reg      <= ul_next;
            count_reg   <= count_next;
            valid_reg   <= valid_next;
            ref_reg     <= ref_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_tuser;
            page_reg <= PW'(s_tdata[PAGE_ID_W-1:0]);
            act_reg  <= act_next;
        end
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        frame_reg      <= frame_next;
        head_reg       <= head_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_evict_reg  <= res_evict_next;
        if (load_m) begin
            m_status_reg <= res_status_reg;
            m_frame_reg  <= FRAME_W'(res_frame_reg);
            m_evict_reg  <= EVICT_W'(res_evict_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        ul_next         = ul_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        ref_next        = ref_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        frame_next      = frame_reg;
        head_next       = head_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_evict_next  = res_evict_reg;
        load_m          = 1'b0;
        pg_we           = 1'b0;
        pg_waddr        = frame_reg;
        pg_wdata        = page_reg;
        pg_raddr        = frame_reg;
        ff_we           = 1'b0;
        ff_waddr        = idx_reg;
        ff_wdata        = frame_reg;
        ff_raddr        = '0;

        case (state_reg)
            S_IDLE: begin
                pg_raddr = '0;
                if (s_tvalid) begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // read of the next frame overlaps the compare of this one
                pg_raddr = idx_reg + FW'(1);
                if (valid_reg[idx_reg] && (pg_rdata == page_reg) && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                end
                if (!valid_reg[idx_reg] && (CW'(idx_reg) < act_reg) && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (int'(idx_reg) == MAX_FRAMES - 1) begin
                    state_next = S_DECIDE;
                end else begin
                    idx_next = idx_reg + FW'(1);
                end
            end
            S_DECIDE: begin
                idx_next = '0;
                if (func_reg == FUNC_RELEASE) begin
                    if (!hit_reg) begin
                        res_status_next = ST_ABSENT;
                        res_frame_next  = '0;
                        res_evict_next  = '0;
                        state_next      = S_DONE;
                    end else begin
                        valid_next[hit_idx_reg] = 1'b0;
                        ref_next[hit_idx_reg]   = 1'b0;
                        res_status_next = ST_RELEASE;
                        res_frame_next  = hit_idx_reg;
                        res_evict_next  = '0;
                        frame_next      = hit_idx_reg;
                        state_next      = (count_reg == '0) ? S_DONE : S_WALK;
                    end
                end else if (hit_reg) begin
                    ref_next[hit_idx_reg] = 1'b1;
                    res_status_next = ST_HIT;
                    res_frame_next  = hit_idx_reg;
                    res_evict_next  = '0;
                    state_next      = S_DONE;
                end else if (free_reg) begin
                    pg_we    = 1'b1;
                    pg_waddr = free_idx_reg;
                    valid_next[free_idx_reg] = 1'b1;
                    ref_next[free_idx_reg]   = 1'b1;
                    if (int'(count_reg) < MAX_FRAMES) begin
                        ff_we      = 1'b1;
                        ff_waddr   = FW'(count_reg);
                        ff_wdata   = free_idx_reg;
                        count_next = count_reg + CW'(1);
                    end
                    res_status_next = ST_LOAD;
                    res_frame_next  = free_idx_reg;
                    res_evict_next  = '0;
                    state_next      = S_DONE;
                end else if (count_reg == '0) begin
                    frame_next = '0;
                    ul_next    = 1'b0;
                    state_next = S_SHIFT_PRE;
                end else begin
                    ul_next    = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                ff_raddr = idx_reg + FW'(1);
                if (func_reg == FUNC_RELEASE) begin
                    if (ff_rdata == frame_reg) begin
                        ul_next    = 1'b1;
                        state_next = S_SHIFT_PRE;
                    end else if (int'(idx_reg) + 1 == int'(count_reg)) begin
                        state_next = S_DONE;
                    end else begin
                        idx_next = idx_reg + FW'(1);
                    end
                end else if (!ref_reg[ff_rdata]) begin
                    frame_next = ff_rdata;
                    state_next = S_SHIFT_PRE;
                end else begin
                    ref_next[ff_rdata] = 1'b0;
                    if (idx_reg == '0) begin
                        head_next = ff_rdata;
                    end
                    if (int'(idx_reg) + 1 == int'(count_reg)) begin
                        // every bit was set: head is the victim
                        frame_next = (idx_reg == '0) ? ff_rdata : head_reg;
                        idx_next   = '0;
                        state_next = S_SHIFT_PRE;
                    end else begin
                        idx_next = idx_reg + FW'(1);
                    end
                end
            end
            S_SHIFT_PRE: begin
                ff_raddr = idx_reg + FW'(1);
                if (ul_reg && (int'(idx_reg) + 1 < int'(count_reg))) begin
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_SHIFT: begin
                ff_raddr = idx_reg + FW'(1) + FW'(1);
                ff_we    = 1'b1;
                ff_waddr = idx_reg;
                ff_wdata = ff_rdata;
                if (int'(idx_reg) + 2 < int'(count_reg)) begin
                    idx_next = idx_reg + FW'(1);
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (func_reg == FUNC_RELEASE) begin
                    count_next = count_reg - CW'(1);
                end else begin
                    res_status_next = ST_REPLACE;
                    res_frame_next  = frame_reg;
                    res_evict_next  = valid_reg[frame_reg] ? pg_rdata : '0;
                    pg_we = 1'b1;
                    valid_next[frame_reg] = 1'b1;
                    ref_next[frame_reg]   = 1'b1;
                    if (ul_reg) begin
                        ff_we    = 1'b1;
                        ff_waddr = FW'(count_reg - CW'(1));
                    end else if (int'(count_reg) < MAX_FRAMES) begin
                        ff_we      = 1'b1;
                        ff_waddr   = FW'(count_reg);
                        count_next = count_reg + CW'(1);
                    end
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    load_m     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load_m) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= MAX_FRAMES)
        else $error("fifo count above frame count");

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (int'(count_reg) == $countones(valid_reg)))
        else $error("fifo count differs from occupied frames");

    a_ref_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ((ref_reg & ~valid_reg) == '0))
        else $error("reference bit set on free frame");

    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_REPLACE)) |-> (m_evict_reg == '0))
        else $error("evicted page on non-replacement word");
`endif

endmodule

/* hw/rtl/scfr_ram.sv */
// ----------------------------------------------------------------------------
// scfr_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scfr_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* bench/frame_replacer_monitor.sv */
// ----------------------------------------------------------------------------
// frame_replacer_monitor
// Watches the config, request and result channels of the second-chance
// frame replacer. Keeps its own copy of the frame table and load queue,
// predicts one outcome per accepted request word and compares every result
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_replacer_monitor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [scfr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [scfr_pkg::S_TDATA_W-1:0]    s_tdata,    // page_id
    input  logic                              s_tuser,    // func
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [scfr_pkg::M_TDATA_W-1:0]    m_tdata,    // frame, evicted_page, zero pad
    input  logic [scfr_pkg::STATUS_W-1:0]     m_tuser,    // status
    output int                                mismatches,
    output int                                pending,
    output int                                checked,
    output int                                replaced
);
    import scfr_pkg::*;

    localparam int NF = MAX_FRAMES_DEF;

    typedef struct packed {
        status_t                status;
        logic [FRAME_W-1:0]     frame;
        logic [EVICT_W-1:0]     evicted;
    } outcome_t;

    logic [PAGE_ID_W-1:0] page_of [NF];
    logic                 held    [NF];
    logic                 ref_set [NF];
    logic [FRAME_W-1:0]   load_order [$];
    logic [CFG_W-1:0]     frames_in_use;
    outcome_t             outcomes [$];
    int                   n_bad;
    int                   n_checked;
    int                   n_replaced;

    task automatic clear_table();
        for (int i = 0; i < NF; i++) begin
            held[i]    = 1'b0;
            ref_set[i] = 1'b0;
            page_of[i] = '0;
        end
        load_order.delete();
        outcomes.delete();
        frames_in_use = CFG_RESET;
    endtask

    task automatic drop_from_queue(input int f);
        int  pos;
        bit  seen;
        pos  = 0;
        seen = 1'b0;
        for (int i = 0; i < load_order.size(); i++) begin
            if (!seen && load_order[i] == f) begin
                pos  = i;
                seen = 1'b1;
            end
        end
        if (seen)
            load_order.delete(pos);
    endtask

    task automatic resolve_access(input logic fn, input logic [PAGE_ID_W-1:0] pg,
                                  output outcome_t o);
        int hit;
        int limit;
        int free_f;
        int pos;
        int f;
        bit found;
        hit = -1;
        for (int i = 0; i < NF; i++)
            if (hit < 0 && held[i] && page_of[i] == pg)
                hit = i;
        o.status  = ST_HIT;
        o.frame   = '0;
        o.evicted = '0;
        if (fn == FUNC_RELEASE) begin
            if (hit < 0) begin
                o.status = ST_ABSENT;
            end else begin
                o.frame      = hit[FRAME_W-1:0];
                held[hit]    = 1'b0;
                ref_set[hit] = 1'b0;
                drop_from_queue(hit);
                o.status     = ST_RELEASE;
            end
        end else if (hit >= 0) begin
            o.frame      = hit[FRAME_W-1:0];
            ref_set[hit] = 1'b1;
        end else begin
            // zero acts as one frame, anything above the table size as the whole table
            limit = (frames_in_use == 0) ? 1 : (frames_in_use > NF) ? NF : int'(frames_in_use);
            free_f = -1;
            for (int i = 0; i < limit; i++)
                if (free_f < 0 && !held[i])
                    free_f = i;
            if (free_f >= 0) begin
                f = free_f;
                if (load_order.size() < NF)
                    load_order.push_back(f[FRAME_W-1:0]);
                o.status = ST_LOAD;
            end else begin
                found = 1'b0;
                pos   = 0;
                for (int i = 0; i < load_order.size(); i++) begin
                    if (!found) begin
                        if (!ref_set[load_order[i]]) begin
                            pos   = i;
                            found = 1'b1;
                        end else begin
                            ref_set[load_order[i]] = 1'b0;
                        end
                    end
                end
                if (load_order.size() > 0) begin
                    f = load_order[pos];
                    load_order.delete(pos);
                end else begin
                    f = 0;
                end
                o.evicted = held[f] ? page_of[f] : '0;
                if (load_order.size() < NF)
                    load_order.push_back(f[FRAME_W-1:0]);
                o.status = ST_REPLACE;
            end
            o.frame    = f[FRAME_W-1:0];
            page_of[f] = pg;
            held[f]    = 1'b1;
            ref_set[f] = 1'b1;
        end
    endtask

    task automatic check_word();
        outcome_t o;
        if (outcomes.size() == 0) begin
            $error("result word with nothing pending: status %0d frame %0d evicted %0d",
                   m_tuser, m_tdata[FRAME_W-1:0], m_tdata[FRAME_W +: EVICT_W]);
            n_bad++;
        end else begin
            o = outcomes.pop_front();
            n_checked++;
            if (o.status == ST_REPLACE)
                n_replaced++;
            if (m_tuser !== o.status) begin
                $error("status: expected %0d, actual %0d", o.status, m_tuser);
                n_bad++;
            end
            if (m_tdata[FRAME_W-1:0] !== o.frame) begin
                $error("frame: expected %0d, actual %0d", o.frame, m_tdata[FRAME_W-1:0]);
                n_bad++;
            end
            if (m_tdata[FRAME_W +: EVICT_W] !== o.evicted) begin
                $error("evicted_page: expected %0d, actual %0d",
                       o.evicted, m_tdata[FRAME_W +: EVICT_W]);
                n_bad++;
            end
            if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0) begin
                $error("zero pad: expected 0, actual %0d", m_tdata[M_TDATA_W-1 -: M_PAD_W]);
                n_bad++;
            end
        end
    endtask

    initial begin
        n_bad      = 0;
        n_checked  = 0;
        n_replaced = 0;
        clear_table();
    end

    always @(posedge aclk) begin : watch
        outcome_t o;
        if (!aresetn) begin
            clear_table();
        end else begin
            if (m_tvalid && m_tready)
                check_word();
            if (cfg_valid && cfg_ready)
                frames_in_use = cfg_data;
            if (s_tvalid && s_tready) begin
                resolve_access(s_tuser, s_tdata, o);
                outcomes.push_back(o);
            end
        end
        mismatches <= n_bad;
        pending    <= outcomes.size();
        checked    <= n_checked;
        replaced   <= n_replaced;
    end

endmodule

/* bench/second_chance_frame_replacer_tb.sv */
// ----------------------------------------------------------------------------
// second_chance_frame_replacer_tb
// Drives page accesses and releases into the frame replacer under several
// frame-count settings and pacing patterns, including a long output hold
// that backs up the request side. Checking is done by the monitor.
// ----------------------------------------------------------------------------
module second_chance_frame_replacer_tb;
    import scfr_pkg::*;

    localparam int RUN_LIMIT   = 1_000_000;
    localparam int SETTLE      = 3 * MAX_FRAMES_DEF + 16;
    localparam int PHASE_WORDS = 140;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {PACE_FULL, PACE_SLOW_SRC, PACE_SLOW_SINK, PACE_BOTH} pace_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // page_id
    logic                   s_tuser   = 1'b0; // func
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // frame, evicted_page, zero pad
    logic [STATUS_W-1:0]    m_tuser;          // status

    int mismatches;
    int pending;
    int checked;
    int replaced;

    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int n_sent = 0;
    int n_settings = 0;

    logic [CFG_W-1:0] phase_frames [12] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd8,
                                            4'd2, 4'd7, 4'd5, 4'd8, 4'd3, 4'd6};

    always #5 aclk = ~aclk;

    second_chance_frame_replacer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    frame_replacer_monitor u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .replaced   (replaced)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold on request
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic set_pace(input pace_t p);
        src_idle_pct   = (p == PACE_SLOW_SRC) ? 82 : (p == PACE_BOTH) ? 17 : 0;
        sink_stall_pct = (p == PACE_SLOW_SINK) ? 82 : (p == PACE_BOTH) ? 17 : 0;
    endtask

    task automatic send_word(input logic fn, input logic [S_TDATA_W-1:0] pg);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= pg;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic random_words(input int count);
        logic [S_TDATA_W-1:0] base;
        int                   span;
        logic                 fn;
        logic [S_TDATA_W-1:0] pg;
        base = $urandom_range(255);
        span = $urandom_range(3, 15);
        for (int i = 0; i < count; i++) begin
            fn = ($urandom_range(99) < 25) ? FUNC_RELEASE : FUNC_ACCESS;
            if ($urandom_range(9) == 0)
                pg = $urandom_range(255);
            else
                pg = base ^ S_TDATA_W'($urandom_range(span));
            send_word(fn, pg);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset frame count, empty table
        set_pace(PACE_FULL);
        send_word(FUNC_RELEASE, 8'h5A);
        send_word(FUNC_ACCESS, 8'h00);
        send_word(FUNC_ACCESS, 8'hFF);
        send_word(FUNC_ACCESS, 8'h00);
        for (int p = 1; p <= 6; p++)
            send_word(FUNC_ACCESS, 8'(p));
        send_word(FUNC_ACCESS, 8'h80);   // all referenced: head goes
        send_word(FUNC_ACCESS, 8'hFF);
        send_word(FUNC_ACCESS, 8'h40);   // victim from mid-queue
        send_word(FUNC_RELEASE, 8'h03);
        send_word(FUNC_RELEASE, 8'h03);  // already gone
        send_word(FUNC_ACCESS, 8'h7E);
        drain();
        // shrink below occupied frames
        write_frames(4'd3);
        send_word(FUNC_ACCESS, 8'h11);
        send_word(FUNC_RELEASE, 8'h06);
        send_word(FUNC_ACCESS, 8'h05);
        send_word(FUNC_ACCESS, 8'h22);
        drain();
        write_frames(4'd0);
        send_word(FUNC_ACCESS, 8'h33);
        drain();
        write_frames(4'd15);
        send_word(FUNC_ACCESS, 8'h44);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            write_frames(phase_frames[ph]);
            set_pace(pace_t'(ph % 4));
            random_words(PHASE_WORDS);
            drain();
        end

        // long output hold while requests keep coming
        write_frames(4'd8);
        set_pace(PACE_FULL);
        hold_req = 1'b1;
        random_words(70);
        drain();

        $display("Sent %0d words across %0d frame-count writes (0, 1, 8 and 15 included),",
                 n_sent, n_settings);
        $display("with idle, stall and hold pacing; %0d results checked, %0d replacements.",
                 checked, replaced);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
